### src/wfg_pkg.sv
package wfg_pkg;

  localparam int unsigned AGENT_COUNT_DEF = 16;

  typedef enum logic [2:0] {
    FUNC_ADD     = 3'd0,
    FUNC_REMOVE  = 3'd1,
    FUNC_CLEAR   = 3'd2,
    FUNC_DETECT  = 3'd3,
    FUNC_RECOVER = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] waiter;
    logic [3:0] holder;
  } wfg_in_t;

  typedef struct packed {
    logic       deadlock_found;
    logic       victim_valid;
    logic [3:0] victim_agent;
  } wfg_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_CHECK,
    ST_SCAN
  } state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DETECT,
    RES_VICTIM
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     close_step;
    logic     scan_step;
    logic     emit;
    res_sel_e sel;
  } wfg_cmd_t;

  typedef struct packed {
    logic last;
    logic hit;
  } wfg_sts_t;

endpackage

### src/wfg_ctrl.sv
module wfg_ctrl import wfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] func_i,
  input  wfg_sts_t   sts_i,
  output wfg_cmd_t   cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_DETECT) begin
            state_d = ST_CLOSE;
          end else if (func_i == FUNC_RECOVER) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLOSE: begin
        if (sts_i.last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = RES_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          // Graph edits and unknown codes answer right away with a zero result.
          if (!(func_i inside {FUNC_DETECT, FUNC_RECOVER})) begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        cmd_o.close_step = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = RES_DETECT;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = RES_VICTIM;
        end else if (sts_i.last) begin
          cmd_o.emit = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### src/wfg_datapath.sv
module wfg_datapath import wfg_pkg::*; #(
  parameter int unsigned AGENT_COUNT = AGENT_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  wfg_in_t  in_i,
  input  wfg_cmd_t cmd_i,
  output wfg_sts_t sts_o,
  output wfg_out_t res_o,
  output logic     strobe_o
);

  localparam int unsigned CW = $clog2(AGENT_COUNT);
  localparam int unsigned IW = (CW > 4) ? CW : 4;

  logic [AGENT_COUNT-1:0] mat_q   [AGENT_COUNT];
  logic [AGENT_COUNT-1:0] mat_d   [AGENT_COUNT];
  logic [AGENT_COUNT-1:0] reach_q [AGENT_COUNT];
  logic [AGENT_COUNT-1:0] reach_d [AGENT_COUNT];
  logic [AGENT_COUNT-1:0] pres_q, pres_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  wfg_out_t               res_q, res_d;
  logic                   strobe_q, strobe_d;

  logic [AGENT_COUNT-1:0] w_hot, h_hot, v_hot, diag;
  logic [AGENT_COUNT-1:0] pivot_row;
  logic                   in_range;
  logic                   do_add, do_remove, do_clear, do_victim;

  always_comb begin
    for (int r = 0; r < AGENT_COUNT; r++) begin
      w_hot[r] = (IW'(r) == IW'(in_i.waiter));
      h_hot[r] = (IW'(r) == IW'(in_i.holder));
      v_hot[r] = (CW'(r) == cnt_q);
      diag[r]  = reach_q[r][r];
    end
  end

  assign in_range  = (|w_hot) && (|h_hot);
  assign pivot_row = reach_q[cnt_q];
  assign do_add    = cmd_i.accept && (in_i.func == FUNC_ADD) && in_range;
  assign do_remove = cmd_i.accept && (in_i.func == FUNC_REMOVE) && in_range;
  assign do_clear  = cmd_i.accept && (in_i.func == FUNC_CLEAR);
  assign do_victim = cmd_i.emit && (cmd_i.sel == RES_VICTIM);

  assign sts_o.last = (cnt_q == CW'(AGENT_COUNT - 1));
  assign sts_o.hit  = pres_q[cnt_q];

  always_comb begin
    pres_d = pres_q;
    for (int r = 0; r < AGENT_COUNT; r++) begin
      mat_d[r] = mat_q[r];
      if (do_add && w_hot[r]) begin
        mat_d[r] = mat_q[r] | h_hot;
      end
      if (do_remove && w_hot[r]) begin
        mat_d[r] = mat_q[r] & ~h_hot;
      end
      if (do_clear) begin
        mat_d[r] = '0;
      end
      // Recovery drops the victim's row and its column in every row.
      if (do_victim) begin
        mat_d[r] = v_hot[r] ? '0 : (mat_q[r] & ~v_hot);
      end
    end
    if (do_add) begin
      pres_d = pres_q | w_hot | h_hot;
    end
    if (do_clear) begin
      pres_d = '0;
    end
    if (do_victim) begin
      pres_d = pres_q & ~v_hot;
    end
  end

  // One closure pivot per cycle. Row k only ORs into itself, so all rows can
  // update in parallel from the same pivot row.
  always_comb begin
    for (int r = 0; r < AGENT_COUNT; r++) begin
      reach_d[r] = reach_q[r];
      if (cmd_i.accept) begin
        reach_d[r] = mat_q[r];
      end else if (cmd_i.close_step && reach_q[r][cnt_q]) begin
        reach_d[r] = reach_q[r] | pivot_row;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept) begin
      cnt_d = '0;
    end else if ((cmd_i.close_step || cmd_i.scan_step) && !sts_o.last) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_comb begin
    res_d    = res_q;
    strobe_d = cmd_i.emit;
    if (cmd_i.emit) begin
      res_d = '0;
      case (cmd_i.sel)
        RES_DETECT: begin
          res_d.deadlock_found = |diag;
        end
        RES_VICTIM: begin
          res_d.victim_valid = 1'b1;
          res_d.victim_agent = 4'(cnt_q);
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < AGENT_COUNT; r++) begin
        mat_q[r] <= '0;
      end
      pres_q   <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      mat_q    <= mat_d;
      pres_q   <= pres_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reach_q <= reach_d;
    res_q   <= res_d;
  end

  assign res_o    = res_q;
  assign strobe_o = strobe_q;

endmodule

### src/wait_for_graph_deadlock_detector.sv
// Channel   Direction  Ports                    Transfer
// command   in         start, busy, cmd_i       start high and busy low at a clock edge
// result    out        strobe_o, res_o          strobe_o high for one cycle, always taken
//
// Add, remove, clear and unknown codes: result in the cycle after the transfer, busy stays low.
// Detect: busy while one transitive closure pivot per cycle runs over all rows of the matrix,
// then the diagonal is checked in the CHECK state.
// Recover: busy while present flags are scanned, one agent a cycle, to a hit or last agent.
// Reset clears the graph at once. The receiver cannot stall; a new command may be taken
// in the cycle that shows a result.
module wait_for_graph_deadlock_detector import wfg_pkg::*; #(
  parameter int unsigned AGENT_COUNT = AGENT_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  wfg_in_t  cmd_i,
  output logic     strobe_o,
  output wfg_out_t res_o
);

  wfg_cmd_t cmd;
  wfg_sts_t sts;

  wfg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (cmd_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  wfg_datapath #(
    .AGENT_COUNT(AGENT_COUNT)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .res_o   (res_o),
    .strobe_o(strobe_o)
  );

  // Graph edits are answered by the registered strobe after the transfer and leave the block idle.
  a_quick_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.func != FUNC_DETECT && cmd_i.func != FUNC_RECOVER)
    |=> (strobe_o && !busy))
    else $error("graph edit did not answer in one cycle");

  a_long_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.func == FUNC_DETECT || cmd_i.func == FUNC_RECOVER))
    |=> (busy && !strobe_o))
    else $error("detect or recover did not occupy the block");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && res_o.victim_valid) |-> !res_o.deadlock_found)
    else $error("result reports both a cycle and a victim");

  a_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !res_o.victim_valid) |-> (res_o.victim_agent == 4'd0))
    else $error("victim number without a victim");

endmodule
